/* design/rlrs_pkg.sv */
package rlrs_pkg;

  localparam int unsigned LINE_DEPTH = 64;
  localparam int unsigned LINE_AW    = $clog2(LINE_DEPTH);
  localparam int unsigned PREFIX_LEN = 7;
  // Number of compared text characters after the prefix (up to 8 plus the end).
  localparam int unsigned TEXT_LEN   = 9;
  localparam int unsigned IDENT_MAX  = 8;

  // "SELECT ", first character in the low byte.
  localparam logic [8*PREFIX_LEN-1:0] SEL_PREFIX = 56'h20_54_43_45_4C_45_53;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_ACK  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [0:0] {
    CFG_UNIT_IDENT = 1'b0,
    CFG_IDENT_LEN  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_RECV    = 3'b001,
    MODE_HELD    = 3'b010,
    MODE_DISCARD = 3'b100
  } mode_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_value;
    logic [5:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic       line_ready;
    logic [5:0] line_length;
    logic       transmit_off;
    logic       discarding;
    logic [7:0] read_data;
  } out_word_t;

  // Captured state of the line being assembled, used for the SELECT check.
  typedef struct packed {
    logic                  prefix_ok;
    logic [LINE_AW-1:0]    length;
    logic [TEXT_LEN*8-1:0] text;
  } sel_line_t;

endpackage

/* design/rs485_line_receiver_select_top.sv */
// Line receiver: one word per cycle, each word answered by one result word in the
// cycle after it is taken. Bytes build a command line (up to 63 bytes) ending at
// CR or LF; the completed line is held until acknowledged, and transmit_off
// pulses on the completing word if the line reads "SELECT <id>" naming another
// unit. The held line sits in a 64-byte single-port-style memory whose
// registered read port serves the read operation; that read register, together
// with the result register, is the one stage of the block. in_ready_o drops only
// while a result waits for out_ready_i.
module rs485_line_receiver_select_top
  import rlrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o
);

  logic [63:0]        unit_ident_q;
  logic [3:0]         ident_length_q;
  mode_e              mode_q, mode_d;
  logic [LINE_AW-1:0] wp_q, wp_d;
  logic               prefix_ok_q, prefix_ok_d;
  logic [7:0]         text_q [TEXT_LEN];
  logic [7:0]         line_mem_q [LINE_DEPTH];
  logic [7:0]         rdata_q;
  logic               rd_en_q, rd_en_d;
  logic               out_valid_q;
  out_word_t          res_q, res_d;

  logic               accept;
  logic               eol;
  logic               mem_we;
  logic               mem_re;
  logic [LINE_AW:0]   wp_inc;
  logic               toff;
  sel_line_t          sel_line;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign eol        = (in_word_i.byte_value == CHAR_LF) || (in_word_i.byte_value == CHAR_CR);
  assign wp_inc     = {1'b0, wp_q} + (LINE_AW + 1)'(1);

  always_comb begin
    sel_line.prefix_ok = prefix_ok_q;
    sel_line.length    = wp_q;
    for (int k = 0; k < TEXT_LEN; k++) begin
      sel_line.text[8*k +: 8] = text_q[k];
    end
  end

  rlrs_select_cmp u_sel (
    .line_i         (sel_line),
    .unit_ident_i   (unit_ident_q),
    .ident_length_i (ident_length_q),
    .other_o        (toff)
  );

  // Next state for one word.
  always_comb begin
    mode_d      = mode_q;
    wp_d        = wp_q;
    prefix_ok_d = prefix_ok_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    rd_en_d     = 1'b0;
    res_d       = '0;
    case (op_e'(in_word_i.operation))
      OP_BYTE: begin
        case (mode_q)
          MODE_DISCARD: begin
            if (eol) begin
              mode_d = MODE_RECV;
              wp_d   = '0;
            end
          end
          MODE_RECV: begin
            if (eol) begin
              mode_d             = MODE_HELD;
              res_d.transmit_off = toff;
            end else begin
              mem_we      = 1'b1;
              prefix_ok_d = ((wp_q == '0) ? 1'b1 : prefix_ok_q) &&
                            ((wp_q >= LINE_AW'(PREFIX_LEN)) ||
                             (in_word_i.byte_value == SEL_PREFIX[8*wp_q[2:0] +: 8]));
              if (wp_inc == (LINE_AW + 1)'(LINE_DEPTH)) begin
                mode_d = MODE_DISCARD;
                wp_d   = '0;
              end else begin
                wp_d = wp_inc[LINE_AW-1:0];
              end
            end
          end
          default: ;
        endcase
      end
      OP_ACK: begin
        mode_d = MODE_RECV;
        wp_d   = '0;
      end
      OP_READ: begin
        if (mode_q == MODE_HELD && in_word_i.read_index < wp_q) begin
          mem_re  = 1'b1;
          rd_en_d = 1'b1;
        end
      end
      default: ;
    endcase
    res_d.line_ready  = (mode_d == MODE_HELD);
    res_d.line_length = (mode_d == MODE_HELD) ? 6'(wp_d) : 6'd0;
    res_d.discarding  = (mode_d == MODE_DISCARD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ident_q   <= '0;
      ident_length_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_UNIT_IDENT: unit_ident_q   <= cfg_data_i;
        CFG_IDENT_LEN:  ident_length_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RECV;
      wp_q        <= '0;
      prefix_ok_q <= 1'b0;
      out_valid_q <= 1'b0;
      rd_en_q     <= 1'b0;
    end else begin
      if (accept) begin
        mode_q      <= mode_d;
        wp_q        <= wp_d;
        prefix_ok_q <= prefix_ok_d;
        rd_en_q     <= rd_en_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload and captured text after the prefix.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
      for (int k = 0; k < TEXT_LEN; k++) begin
        if (mem_we && wp_q == LINE_AW'(PREFIX_LEN + k)) begin
          text_q[k] <= in_word_i.byte_value;
        end
      end
    end
  end

  // Line memory: write at the fill position, registered read at the read index.
  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      line_mem_q[wp_q] <= in_word_i.byte_value;
    end
    if (accept && mem_re) begin
      rdata_q <= line_mem_q[in_word_i.read_index];
    end
  end

  always_comb begin
    out_word_o           = res_q;
    out_word_o.read_data = rd_en_q ? rdata_q : 8'h00;
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/rlrs_select_cmp.sv */
module rlrs_select_cmp
  import rlrs_pkg::*;
(
  input  sel_line_t   line_i,
  input  logic [63:0] unit_ident_i,
  input  logic [3:0]  ident_length_i,
  output logic        other_o
);

  logic [3:0] n_chars;
  logic       done;
  logic       res;
  logic [7:0] tc;
  logic [7:0] ic;

  assign n_chars = (ident_length_i > 4'(IDENT_MAX)) ? 4'(IDENT_MAX) : ident_length_i;

  // Walk the text after the prefix; first difference or terminating zero decides.
  always_comb begin
    done = 1'b0;
    res  = 1'b1;
    tc   = '0;
    ic   = '0;
    for (int k = 0; k < TEXT_LEN; k++) begin
      tc = (LINE_AW'(PREFIX_LEN + k) < line_i.length) ? line_i.text[8*k +: 8] : 8'h00;
      ic = (k < IDENT_MAX && 4'(k) < n_chars) ? unit_ident_i[8*(k % IDENT_MAX) +: 8] : 8'h00;
      if (!done) begin
        if (tc != ic) begin
          res  = 1'b1;
          done = 1'b1;
        end else if (tc == 8'h00) begin
          res  = 1'b0;
          done = 1'b1;
        end
      end
    end
    other_o = (line_i.length >= LINE_AW'(PREFIX_LEN)) && line_i.prefix_ok && res;
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb
  import rlrs_pkg::*;
;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [7:0]  ASCII_LF    = 8'h0A;
  localparam logic [7:0]  ASCII_CR    = 8'h0D;
  localparam logic [55:0] SELECT_TEXT = "SELECT ";
  localparam int unsigned STALL_LIMIT = 1000;

  // Tracks the receiver state and predicts the status word of each accepted word.
  class held_line_tracker;
    mode_e       mode;
    int unsigned wpos;
    logic [7:0]  store [LINE_DEPTH];
    logic [63:0] ident;
    logic [3:0]  ident_len;
    out_word_t   status_due_q[$];
    int unsigned errors;

    function new();
      mode      = MODE_RECV;
      wpos      = 0;
      ident     = '0;
      ident_len = '0;
      errors    = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [63:0] data);
      if (idx == CFG_UNIT_IDENT) begin
        ident = data;
      end else begin
        ident_len = data[3:0];
      end
    endfunction

    // The line names another unit: prefix matches, the text after it differs.
    function bit names_other_unit();
      int unsigned n;
      int unsigned pos;
      logic [7:0]  tc;
      logic [7:0]  ic;
      if (wpos < 7) return 1'b0;
      for (int i = 0; i < 7; i++) begin
        if (store[i] != SELECT_TEXT[8*(6-i) +: 8]) return 1'b0;
      end
      n = (ident_len > 8) ? 8 : ident_len;
      for (int k = 0; k <= 8; k++) begin
        pos = 7 + k;
        tc  = (pos < wpos) ? store[pos] : 8'h00;
        ic  = (k < n) ? ident[8*k +: 8] : 8'h00;
        if (tc != ic) return 1'b1;
        if (tc == 8'h00) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_word(in_word_t w);
      out_word_t st;
      logic       toff;
      logic [7:0] rdata;
      bit         eol;
      toff  = 1'b0;
      rdata = 8'h00;
      eol   = (w.byte_value == ASCII_LF) || (w.byte_value == ASCII_CR);
      case (w.operation)
        OP_BYTE: begin
          if (mode == MODE_DISCARD) begin
            if (eol) begin
              mode = MODE_RECV;
              wpos = 0;
            end
          end else if (mode == MODE_RECV) begin
            if (eol) begin
              toff = names_other_unit();
              mode = MODE_HELD;
            end else begin
              store[wpos] = w.byte_value;
              wpos++;
              if (wpos >= LINE_DEPTH) begin
                mode = MODE_DISCARD;
                wpos = 0;
              end
            end
          end
        end
        OP_ACK: begin
          mode = MODE_RECV;
          wpos = 0;
        end
        OP_READ: begin
          if (mode == MODE_HELD && w.read_index < wpos) rdata = store[w.read_index];
        end
        default: ;
      endcase
      st.line_ready   = (mode == MODE_HELD);
      st.line_length  = (mode == MODE_HELD) ? 6'(wpos) : 6'd0;
      st.transmit_off = toff;
      st.discarding   = (mode == MODE_DISCARD);
      st.read_data    = rdata;
      status_due_q.push_back(st);
    endfunction

    function void check_status(out_word_t got);
      out_word_t want;
      if (status_due_q.size() == 0) begin
        $error("status word with nothing outstanding: %h", got);
        errors++;
        return;
      end
      want = status_due_q.pop_front();
      if (got.line_ready !== want.line_ready) begin
        $error("line_ready: expected %0d, got %0d", want.line_ready, got.line_ready);
        errors++;
      end
      if (got.line_length !== want.line_length) begin
        $error("line_length: expected %0d, got %0d", want.line_length, got.line_length);
        errors++;
      end
      if (got.transmit_off !== want.transmit_off) begin
        $error("transmit_off: expected %0d, got %0d", want.transmit_off, got.transmit_off);
        errors++;
      end
      if (got.discarding !== want.discarding) begin
        $error("discarding: expected %0d, got %0d", want.discarding, got.discarding);
        errors++;
      end
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_word_t    in_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_word_t   out_word_o;

  held_line_tracker tracker = new();
  int unsigned      words_sent = 0;
  int unsigned      burst_left = 0;
  int unsigned      quiet_cycles = 0;

  rs485_line_receiver_select_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Note accepted words before checking, so a same-edge result stays ordered.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tracker.take_word(in_word_i);
      if (out_valid_o && out_ready_i) tracker.check_status(out_word_o);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Receiver stall pattern: rotate through steady, random, sparse and periodic.
  initial begin
    int unsigned tick;
    tick        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      case ((tick / 150) % 4)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (tick % 7) < 3;
      endcase
    end
  end

  function automatic logic [63:0] pack_ident(string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic logic [7:0] line_char();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == ASCII_CR || b == ASCII_LF) b = 8'h7E;
    return b;
  endfunction

  function automatic logic [7:0] eol_char();
    return $urandom_range(0, 1) ? ASCII_CR : ASCII_LF;
  endfunction

  task automatic send_word(logic [1:0] op, logic [7:0] b, logic [5:0] idx);
    in_word_t    w;
    int unsigned gap;
    w.operation  = op;
    w.byte_value = b;
    w.read_index = idx;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(OP_BYTE, b, 6'($urandom_range(0, 63)));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_read(int unsigned len);
    int unsigned hi;
    hi = (len + 1 > 63) ? 63 : len + 1;
    if ($urandom_range(0, 2) == 0) hi = 63;
    send_word(OP_READ, 8'($urandom_range(0, 255)), 6'($urandom_range(0, hi)));
  endtask

  task automatic send_ack();
    send_word(OP_ACK, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
  endtask

  // Drop valid and wait until every status word is back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (tracker.status_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    tracker.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_unit(logic [63:0] ident, logic [63:0] len_word);
    drain();
    write_reg(CFG_UNIT_IDENT, ident);
    write_reg(CFG_IDENT_LEN, len_word);
  endtask

  // Mostly well-formed lines with random content; the rest is noise.
  task automatic run_traffic(int unsigned count);
    logic [7:0]  line_q[$];
    int unsigned quota;
    int unsigned kind;
    int unsigned n;
    bit          long_line;
    quota = words_sent + count;
    while (words_sent < quota) begin
      line_q.delete();
      long_line = 1'b0;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        for (int i = 0; i < 7; i++) line_q.push_back(SELECT_TEXT[8*(6-i) +: 8]);
        if ($urandom_range(0, 9) == 0) line_q[$urandom_range(0, 6)] = line_char();
        n = (tracker.ident_len > 8) ? 8 : tracker.ident_len;
        case ($urandom_range(0, 3))
          0, 1: for (int k = 0; k < n; k++) line_q.push_back(tracker.ident[8*k +: 8]);
          2: begin
            for (int k = 0; k < n; k++) line_q.push_back(tracker.ident[8*k +: 8]);
            if (n != 0 && $urandom_range(0, 1)) begin
              line_q[$urandom_range(7, line_q.size() - 1)] = line_char();
            end else if (n != 0 && $urandom_range(0, 1)) begin
              void'(line_q.pop_back());
            end else begin
              line_q.push_back(line_char());
            end
          end
          default: repeat ($urandom_range(0, 10)) line_q.push_back(line_char());
        endcase
        if ($urandom_range(0, 7) == 0) begin
          line_q.push_back(8'h00);
          repeat ($urandom_range(0, 3)) line_q.push_back(line_char());
        end
      end else if (kind < 70) begin
        repeat ($urandom_range(0, 20)) line_q.push_back(line_char());
      end else if (kind < 80) begin
        long_line = 1'b1;
        repeat ($urandom_range(58, 70)) line_q.push_back(line_char());
      end
      if (kind < 80) begin
        foreach (line_q[i]) send_byte(line_q[i]);
        // bytes after an overflow are dropped
        if (long_line) repeat ($urandom_range(0, 3)) send_byte(line_char());
        send_byte(eol_char());
        if ($urandom_range(0, 9) == 0) send_byte(line_char());
        repeat ($urandom_range(0, 4)) send_read(line_q.size());
        if ($urandom_range(0, 6) != 0) send_ack();
      end else if (kind < 90) begin
        repeat ($urandom_range(0, 70)) send_byte(line_char());
        send_ack();
      end else begin
        send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  6'($urandom_range(0, 63)));
      end
    end
  endtask

  initial begin
    logic [63:0] mixed;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_UNIT_IDENT;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_UNIT_IDENT, pack_ident("U7"));
    write_reg(CFG_IDENT_LEN, 64'd2);
    send_word(OP_UNUSED, 8'hFF, 6'h3F);
    send_word(OP_BYTE, ASCII_CR, 6'h00);  // empty line
    send_word(OP_BYTE, 8'h41, 6'h00);     // ignored while held
    send_word(OP_READ, 8'h00, 6'h3F);
    send_word(OP_READ, 8'hFF, 6'h00);
    send_word(OP_ACK, 8'h00, 6'h00);
    send_text("SELECT U7");
    send_word(OP_BYTE, ASCII_CR, 6'h3F);
    send_word(OP_READ, 8'h00, 6'd8);
    send_word(OP_UNUSED, 8'h00, 6'h00);
    send_word(OP_ACK, 8'hFF, 6'h3F);
    // zero right after the prefix ends the compared text
    send_text("SELECT ");
    send_word(OP_BYTE, 8'h00, 6'h00);
    send_word(OP_BYTE, 8'hFF, 6'h00);
    send_word(OP_BYTE, ASCII_LF, 6'h00);
    send_word(OP_READ, 8'h00, 6'd8);
    send_word(OP_ACK, 8'h00, 6'h00);
    send_word(OP_ACK, 8'h00, 6'h00);

    set_unit(64'd0, 64'd0);
    run_traffic(300);
    set_unit(pack_ident("UNIT0007"), 64'd8);
    run_traffic(300);
    mixed = {$urandom, $urandom};
    set_unit('1, {mixed[63:4], 4'hF});
    run_traffic(300);
    mixed = {$urandom, $urandom};
    set_unit({mixed[63:16], 16'(pack_ident("AB"))}, 64'd2);
    run_traffic(300);
    for (int i = 0; i < 8; i++) mixed[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
    set_unit(mixed, 64'($urandom_range(0, 15)));
    run_traffic(300);
    set_unit(pack_ident("X") | (pack_ident("YZ") << 16), 64'd8);
    run_traffic(300);

    drain();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
